/* design/bot_pkg.sv */
// Shared types and constants for the bounce-out tween block.
package bot_pkg;

	localparam int DT_BITS      = 16;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_X = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_Y = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DURATION = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_EASE,
		ST_SQUARE,
		ST_SCALE_X,
		ST_SCALE_Y,
		ST_PUT
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic ease_step;
		logic sq_step;
		logic scale_x;
		logic scale_y;
		logic out_load;
	} bot_cmd_t;

	typedef struct packed {
		logic finished;
	} bot_sts_t;

endpackage

/* design/bot_ctrl.sv */
// Sequencing controller for the bounce-out tween.
module bot_ctrl #(
	parameter int EASE_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	output logic              result_valid,
	input  logic              result_ready,
	input  bot_pkg::bot_sts_t sts,
	output bot_pkg::bot_cmd_t cmd
);
	import bot_pkg::*;

	localparam int CNT_W = $clog2(EASE_FRAC_BITS);

	ctl_state_t       state_q, state_d;
	logic [CNT_W-1:0] div_cnt_q, div_cnt_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			div_cnt_q <= div_cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		div_cnt_d  = div_cnt_q;
		cmd        = '0;
		tick_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				tick_ready = 1'b1;
				if (tick_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				div_cnt_d = '0;
				state_d   = sts.finished ? ST_PUT : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_d    = div_cnt_q + 1'b1;
				if (div_cnt_q == CNT_W'(EASE_FRAC_BITS - 1)) begin
					state_d = ST_EASE;
				end
			end
			ST_EASE: begin
				cmd.ease_step = 1'b1;
				state_d       = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.sq_step = 1'b1;
				state_d     = ST_SCALE_X;
			end
			ST_SCALE_X: begin
				cmd.scale_x = 1'b1;
				state_d     = ST_SCALE_Y;
			end
			ST_SCALE_Y: begin
				cmd.scale_y = 1'b1;
				state_d     = ST_PUT;
			end
			ST_PUT: begin
				if (!out_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

endmodule

/* design/bot_dp.sv */
// Datapath: config registers, elapsed time, divider, ease curve and scaling.
module bot_dp #(
	parameter int TIME_BITS      = 24,
	parameter int COORD_BITS     = 16,
	parameter int EASE_FRAC_BITS = 16,
	parameter int CFG_W          = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [bot_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [CFG_W-1:0]                      cfg_wdata,
	input  logic [bot_pkg::DT_BITS-1:0]           delta_time,
	input  bot_pkg::bot_cmd_t                     cmd,
	output bot_pkg::bot_sts_t                     sts,
	output logic signed [COORD_BITS:0]            offset_x,
	output logic signed [COORD_BITS:0]            offset_y,
	output logic                                  done_res
);
	import bot_pkg::*;

	localparam int TB    = TIME_BITS;
	localparam int CB    = COORD_BITS;
	localparam int F     = EASE_FRAC_BITS;
	localparam int SUM_W = ((TB > DT_BITS) ? TB : DT_BITS) + 1;
	localparam int ONE   = 1 << F;

	localparam logic [F+3:0] LIM_A = (F+4)'(4) << F;
	localparam logic [F+3:0] LIM_B = (F+4)'(8) << F;
	localparam logic [F+3:0] LIM_C = (F+4)'(10) << F;
	localparam logic [F+4:0] M_B   = (F+5)'(12) << F;
	localparam logic [F+4:0] M_C   = (F+5)'(18) << F;
	localparam logic [F+4:0] M_D   = (F+5)'(21) << F;
	localparam logic [F-1:0] K_B   = F'((ONE * 3) / 4);
	localparam logic [F-1:0] K_C   = F'((ONE * 15) / 16);
	localparam logic [F-1:0] K_D   = F'((ONE * 63) / 64);

	logic signed [CB-1:0] src_x_q, src_y_q, tgt_x_q, tgt_y_q;
	logic [TB-1:0]        dur_q;
	logic [TB-1:0]        elapsed_q;
	logic                 fin_q;

	logic [TB:0]          rem_q;
	logic [F-1:0]         quo_q;
	logic [F+2:0]         ad_q;
	logic [F-1:0]         k_q;
	logic [F-1:0]         ease_q;
	logic signed [CB:0]   scl_x_q, scl_y_q;
	logic signed [CB:0]   off_x_q, off_y_q;
	logic                 done_q;

	logic signed [CB:0]   dx, dy;
	logic [SUM_W-1:0]     sum;
	logic [TB-1:0]        elapsed_new;
	logic [TB:0]          rem_dbl;
	logic                 rem_ge;
	logic [F+3:0]         t11;
	logic [F+4:0]         t22;
	logic [F+4:0]         m_sel;
	logic [F-1:0]         k_sel;
	logic [F+4:0]         dd;
	logic [F+4:0]         dd_abs;
	logic [2*F+5:0]       sq;
	logic signed [CB:0]   mul_a;
	logic signed [F:0]    mul_b;
	logic signed [CB+F+1:0] prod;
	logic signed [CB+F+1:0] prod_adj;

	assign dx = CB'(0) + ((CB+1)'(tgt_x_q) - (CB+1)'(src_x_q));
	assign dy = CB'(0) + ((CB+1)'(tgt_y_q) - (CB+1)'(src_y_q));

	assign sum         = SUM_W'(elapsed_q) + SUM_W'(delta_time);
	assign elapsed_new = (sum > SUM_W'(dur_q)) ? dur_q : sum[TB-1:0];

	assign rem_dbl = {rem_q[TB-1:0], 1'b0};
	assign rem_ge  = rem_dbl >= {1'b0, dur_q};

	assign t11 = {1'b0, quo_q, 3'b000} + {3'b000, quo_q, 1'b0} + {4'b0000, quo_q};
	assign t22 = {t11, 1'b0};

	always_comb begin
		if (t11 < LIM_A) begin
			m_sel = '0;
			k_sel = '0;
		end else if (t11 < LIM_B) begin
			m_sel = M_B;
			k_sel = K_B;
		end else if (t11 < LIM_C) begin
			m_sel = M_C;
			k_sel = K_C;
		end else begin
			m_sel = M_D;
			k_sel = K_D;
		end
	end

	assign dd     = t22 - m_sel;
	assign dd_abs = dd[F+4] ? (~dd + 1'b1) : dd;

	assign sq = ad_q * ad_q;

	assign mul_a    = cmd.scale_y ? dy : dx;
	assign mul_b    = {1'b0, ease_q};
	assign prod     = mul_a * mul_b;
	assign prod_adj = prod + {{(CB+2){1'b0}}, {F{prod[CB+F+1]}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_x_q   <= '0;
			src_y_q   <= '0;
			tgt_x_q   <= '0;
			tgt_y_q   <= '0;
			dur_q     <= TB'(1);
			elapsed_q <= '0;
			fin_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SOURCE_X: src_x_q <= cfg_wdata[CB-1:0];
					REG_SOURCE_Y: src_y_q <= cfg_wdata[CB-1:0];
					REG_TARGET_X: tgt_x_q <= cfg_wdata[CB-1:0];
					REG_TARGET_Y: tgt_y_q <= cfg_wdata[CB-1:0];
					REG_DURATION: dur_q   <= cfg_wdata[TB-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				elapsed_q <= elapsed_new;
				if (elapsed_new >= dur_q) begin
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= {1'b0, elapsed_new};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? (rem_dbl - {1'b0, dur_q}) : rem_dbl;
			quo_q <= {quo_q[F-2:0], rem_ge};
		end
		if (cmd.ease_step) begin
			ad_q <= dd_abs[F+2:0];
			k_q  <= k_sel;
		end
		if (cmd.sq_step) begin
			ease_q <= sq[2*F+5:F+6] + k_q;
		end
		if (cmd.scale_x) begin
			scl_x_q <= prod_adj[CB+F:F];
		end
		if (cmd.scale_y) begin
			scl_y_q <= prod_adj[CB+F:F];
		end
		if (cmd.out_load) begin
			off_x_q <= fin_q ? dx : scl_x_q;
			off_y_q <= fin_q ? dy : scl_y_q;
			done_q  <= fin_q;
		end
	end

	assign sts.finished = fin_q;
	assign offset_x     = off_x_q;
	assign offset_y     = off_y_q;
	assign done_res     = done_q;

endmodule

/* design/bounce_out_tween.sv */
// Top level of the bounce-out tween: controller plus datapath.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+-------------------------------
//   config   | cfg_wr_en                  | cfg_index, cfg_wdata
//   tick     | tick_valid / tick_ready    | delta_time
//   result   | result_valid / result_ready| offset_x, offset_y, done_res
//
// A tick that leaves the animation running passes the restoring divider,
// which yields one bit of progress per cycle, then the ease, square and
// X and Y scaling steps; a tick once finished goes straight to output.
// Results wait in an output register; the next tick is taken meanwhile,
// and its result is held back only until the previous word is taken.
// Reset clears elapsed time and the finished flag and loads register defaults.
module bounce_out_tween #(
	parameter int TIME_BITS      = 24,
	parameter int COORD_BITS     = 16,
	parameter int EASE_FRAC_BITS = 16
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   cfg_wr_en,
	input  logic [bot_pkg::CFG_IDX_BITS-1:0]                       cfg_index,
	input  logic [((COORD_BITS > TIME_BITS) ? COORD_BITS : TIME_BITS)-1:0] cfg_wdata,
	input  logic                                                   tick_valid,
	output logic                                                   tick_ready,
	input  logic [bot_pkg::DT_BITS-1:0]                            delta_time,
	output logic                                                   result_valid,
	input  logic                                                   result_ready,
	output logic signed [COORD_BITS:0]                             offset_x,
	output logic signed [COORD_BITS:0]                             offset_y,
	output logic                                                   done_res
);
	import bot_pkg::*;

	localparam int CFG_W = (COORD_BITS > TIME_BITS) ? COORD_BITS : TIME_BITS;

	bot_cmd_t cmd;
	bot_sts_t sts;

	bot_ctrl #(
		.EASE_FRAC_BITS(EASE_FRAC_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.tick_ready  (tick_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	bot_dp #(
		.TIME_BITS     (TIME_BITS),
		.COORD_BITS    (COORD_BITS),
		.EASE_FRAC_BITS(EASE_FRAC_BITS),
		.CFG_W         (CFG_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.delta_time(delta_time),
		.cmd       (cmd),
		.sts       (sts),
		.offset_x  (offset_x),
		.offset_y  (offset_y),
		.done_res  (done_res)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.div_step, cmd.ease_step, cmd.sq_step,
			cmd.scale_x, cmd.scale_y, cmd.out_load}))
		else $error("more than one datapath command at once");

	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sts.finished |=> sts.finished)
		else $error("finished flag cleared without reset");

	a_done_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && done_res) |-> sts.finished)
		else $error("done word without finished state");

	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && tick_ready) |=> !tick_ready)
		else $error("tick taken while previous tick in progress");

endmodule
